// ===== src/mexu_pkg.sv =====
// Shared types and codes for the MIPS32 integer execute unit.
`default_nettype none
package mexu_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned DIV_STEPS = 32;

    typedef enum logic [6:0] {
        OP_NOP, OP_SSNOP, OP_WAIT, OP_SLL, OP_SRL, OP_SRA, OP_SLLV, OP_SRLV, OP_SRAV,
        OP_JR, OP_JR_HB, OP_JALR, OP_JALR_HB, OP_MOVZ, OP_MOVN, OP_SYSCALL,
        OP_BREAK, OP_SYNC, OP_MFHI, OP_MTHI, OP_MFLO, OP_MTLO, OP_MULT, OP_MULTU,
        OP_DIV, OP_DIVU, OP_ADD, OP_ADDU, OP_SUB, OP_SUBU, OP_AND, OP_OR, OP_XOR,
        OP_NOR, OP_SLT, OP_SLTU, OP_TGE, OP_TGEU, OP_TLT, OP_TLTU, OP_TEQ, OP_TNE,
        OP_BLTZ, OP_BLTZL, OP_BLTZAL, OP_BLTZALL, OP_BGEZ, OP_BGEZL, OP_BGEZAL,
        OP_BGEZALL, OP_TGEI, OP_TGEIU, OP_TLTI, OP_TLTIU, OP_TEQI, OP_TNEI, OP_J,
        OP_JAL, OP_BEQ, OP_BEQL, OP_BNE, OP_BNEL, OP_BLEZ, OP_BLEZL, OP_BGTZ,
        OP_BGTZL, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI,
        OP_LUI, OP_MADD, OP_MADDU, OP_MUL, OP_MSUB, OP_MSUBU, OP_CLZ, OP_CLO,
        OP_LB, OP_LBU, OP_LWL, OP_LWR, OP_SB, OP_SWL, OP_SWR, OP_LH, OP_LHU, OP_SH,
        OP_LW, OP_LL, OP_SW, OP_SC, OP_CACHE, OP_PREF
    } op_e;

    typedef enum logic [2:0] {
        EXC_NONE        = 3'd0,
        EXC_OVERFLOW    = 3'd1,
        EXC_TRAP        = 3'd2,
        EXC_BREAK       = 3'd3,
        EXC_SYSTEM_CALL = 3'd4,
        EXC_MISALIGN    = 3'd5
    } exc_e;

    typedef struct packed {
        logic [6:0]  operation;
        logic [31:0] rs_value;
        logic [31:0] rt_value;
        logic [4:0]  shift_amount;
        logic [15:0] immediate;
        logic [31:0] pc_value;
        logic [25:0] jump_index;
        logic [31:0] hi_in;
        logic [31:0] lo_in;
    } cmd_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic [31:0] hi_out;
        logic [31:0] lo_out;
        logic [31:0] target_pc;
        logic        condition;
        logic [31:0] mem_address;
        logic [2:0]  exception_code;
        logic        undefined_op;
    } res_t;

    typedef struct packed {
        logic div_en;
        logic neg_q;
        logic neg_r;
    } div_ctl_t;

endpackage
`default_nettype wire

// ===== src/mexu_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, carrying the result item along.
`default_nettype none
module mexu_div (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 valid_in,
    input  wire logic [31:0]          dividend,
    input  wire logic [31:0]          divisor,
    input  wire mexu_pkg::div_ctl_t   ctl,
    input  wire mexu_pkg::res_t       item_in,
    output logic                      valid_out,
    output mexu_pkg::res_t            item_out
);
    import mexu_pkg::*;

    logic              valid_reg [DIV_STEPS];
    logic [DATA_W-1:0] rem_reg   [DIV_STEPS];
    logic [DATA_W-1:0] quo_reg   [DIV_STEPS];
    logic [DATA_W-1:0] den_reg   [DIV_STEPS];
    div_ctl_t          ctl_reg   [DIV_STEPS];
    res_t              item_reg  [DIV_STEPS];

    logic              out_valid_reg;
    res_t              out_item_reg;
    res_t              out_item_next;

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
        logic              v_src;
        logic [DATA_W-1:0] rem_src;
        logic [DATA_W-1:0] quo_src;
        logic [DATA_W-1:0] den_src;
        div_ctl_t          ctl_src;
        res_t              item_src;
        logic [DATA_W:0]   shifted;
        logic [DATA_W+1:0] diff;
        logic              ge;

        if (i == 0) begin : g_first
            assign v_src    = valid_in;
            assign rem_src  = '0;
            assign quo_src  = dividend;
            assign den_src  = divisor;
            assign ctl_src  = ctl;
            assign item_src = item_in;
        end
        else begin : g_next
            assign v_src    = valid_reg[i-1];
            assign rem_src  = rem_reg[i-1];
            assign quo_src  = quo_reg[i-1];
            assign den_src  = den_reg[i-1];
            assign ctl_src  = ctl_reg[i-1];
            assign item_src = item_reg[i-1];
        end

        // Bring down the next dividend bit and try the subtraction.
        assign shifted = {rem_src, quo_src[DATA_W-1]};
        assign diff    = {1'b0, shifted} - {2'b00, den_src};
        assign ge      = ~diff[DATA_W+1];

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= v_src;
            end
        end

        always_ff @(posedge clk) begin
            rem_reg[i]  <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_reg[i]  <= {quo_src[DATA_W-2:0], ge};
            den_reg[i]  <= den_src;
            ctl_reg[i]  <= ctl_src;
            item_reg[i] <= item_src;
        end
    end

    // Sign fix-up of quotient and remainder for the signed divide.
    always_comb begin
        out_item_next = item_reg[DIV_STEPS-1];
        if (ctl_reg[DIV_STEPS-1].div_en)
        begin
            out_item_next.lo_out = ctl_reg[DIV_STEPS-1].neg_q ?
                                   (32'd0 - quo_reg[DIV_STEPS-1]) : quo_reg[DIV_STEPS-1];
            out_item_next.hi_out = ctl_reg[DIV_STEPS-1].neg_r ?
                                   (32'd0 - rem_reg[DIV_STEPS-1]) : rem_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= valid_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk) begin
        out_item_reg <= out_item_next;
    end

    assign valid_out = out_valid_reg;
    assign item_out  = out_item_reg;

endmodule
`default_nettype wire

// ===== src/mips32_integer_execute_unit_core.sv =====
// Top level of the MIPS32 integer execute unit: decode, ALU, multiply and divide pipeline.
`default_nettype none
// Every item takes the same path: stages A to D, then the divider stages and the divider's
// output register, which drives done and result.
// Throughput: one item per cycle, set by the fully pipelined 32-stage divider and the
// three-stage multiply/accumulate path; busy is always low.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.
// The receiver cannot stall: each result item is shown on result for exactly one cycle.
module mips32_integer_execute_unit_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire mexu_pkg::cmd_t  command,
    output logic                 done,
    output mexu_pkg::res_t       result
);
    import mexu_pkg::*;

    // Item record for the front stages. The output fields are filled in as early as
    // possible; the product and the divider operands ride along until they are used.
    typedef struct packed {
        res_t        item;
        logic [63:0] prod;
        logic [31:0] corr;
        logic        mul_hilo;
        logic        mul_signed;
        logic        acc_add;
        logic        acc_sub;
        logic        mul_res;
        div_ctl_t    dctl;
        logic [31:0] div_a;
        logic [31:0] div_b;
    } pipe_t;

    // Leading zero count by halving, five dependent steps.
    function automatic logic [5:0] clz32(input logic [31:0] v);
        logic [31:0] x;
        logic [5:0]  n;
        begin
            x = v;
            n = 6'd0;
            if (v == 32'd0)
            begin
                n = 6'd32;
            end
            else
            begin
                if (x[31:16] == 16'd0) begin n = n + 6'd16; x = x << 16; end
                if (x[31:24] == 8'd0)  begin n = n + 6'd8;  x = x << 8;  end
                if (x[31:28] == 4'd0)  begin n = n + 6'd4;  x = x << 4;  end
                if (x[31:30] == 2'd0)  begin n = n + 6'd2;  x = x << 2;  end
                if (x[31] == 1'b0)     begin n = n + 6'd1;               end
            end
            return n;
        end
    endfunction

    logic  a_valid_reg;
    cmd_t  a_cmd_reg;
    logic  b_valid_reg, c_valid_reg, d_valid_reg;
    pipe_t b_reg, c_reg, d_reg;
    pipe_t b_next, c_next, d_next;

    // Stage A: register the accepted command.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        a_cmd_reg <= command;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
    end

    // Stage B: decode, the ALU work that completes in this stage, unsigned 32x32 product, divider operand prep.
    logic [31:0] rs, rt, si, pc, link, btgt, sum, dif, addr;
    logic        lt_s, lt_u, lti_s, lti_u;

    always_comb begin
        rs    = a_cmd_reg.rs_value;
        rt    = a_cmd_reg.rt_value;
        pc    = a_cmd_reg.pc_value;
        si    = {{16{a_cmd_reg.immediate[15]}}, a_cmd_reg.immediate};
        link  = pc + 32'd8;
        btgt  = pc + {si[29:0], 2'b00} + 32'd4;
        sum   = rs + rt;
        dif   = rs - rt;
        addr  = rs + si;
        lt_s  = $signed(rs) < $signed(rt);
        lt_u  = rs < rt;
        lti_s = $signed(rs) < $signed(si);
        lti_u = rs < si;

        b_next = '0;
        b_next.item.hi_out = a_cmd_reg.hi_in;
        b_next.item.lo_out = a_cmd_reg.lo_in;
        b_next.item.exception_code = EXC_NONE;
        b_next.prod  = 64'(rs) * 64'(rt);
        b_next.corr  = (rs[31] ? rt : 32'd0) + (rt[31] ? rs : 32'd0);
        b_next.div_a = rs;
        b_next.div_b = rt;

        case (op_e'(a_cmd_reg.operation))
            OP_NOP, OP_SSNOP, OP_WAIT, OP_SYNC, OP_CACHE, OP_PREF: ;
            OP_SLL:  b_next.item.result_value = rt << a_cmd_reg.shift_amount;
            OP_SRL:  b_next.item.result_value = rt >> a_cmd_reg.shift_amount;
            OP_SRA:  b_next.item.result_value = 32'($signed(rt) >>> a_cmd_reg.shift_amount);
            OP_SLLV: b_next.item.result_value = rt << rs[4:0];
            OP_SRLV: b_next.item.result_value = rt >> rs[4:0];
            OP_SRAV: b_next.item.result_value = 32'($signed(rt) >>> rs[4:0]);
            OP_JR, OP_JR_HB:
            begin
                b_next.item.target_pc = rs;
                b_next.item.condition = 1'b1;
            end
            OP_JALR, OP_JALR_HB:
            begin
                b_next.item.result_value = link;
                b_next.item.target_pc    = rs;
                b_next.item.condition    = 1'b1;
            end
            OP_MOVZ:
            begin
                b_next.item.result_value = rs;
                b_next.item.condition    = (rt == 32'd0);
            end
            OP_MOVN:
            begin
                b_next.item.result_value = rs;
                b_next.item.condition    = (rt != 32'd0);
            end
            OP_SYSCALL: b_next.item.exception_code = EXC_SYSTEM_CALL;
            OP_BREAK:   b_next.item.exception_code = EXC_BREAK;
            OP_MFHI:    b_next.item.result_value = a_cmd_reg.hi_in;
            OP_MTHI:    b_next.item.hi_out = rs;
            OP_MFLO:    b_next.item.result_value = a_cmd_reg.lo_in;
            OP_MTLO:    b_next.item.lo_out = rs;
            OP_MULT:
            begin
                b_next.mul_hilo   = 1'b1;
                b_next.mul_signed = 1'b1;
            end
            OP_MULTU: b_next.mul_hilo = 1'b1;
            OP_DIV:
            begin
                if (rt != 32'd0 && !(rs == 32'h8000_0000 && rt == 32'hffff_ffff))
                begin
                    b_next.dctl.div_en = 1'b1;
                    b_next.dctl.neg_q  = rs[31] ^ rt[31];
                    b_next.dctl.neg_r  = rs[31];
                    b_next.div_a = rs[31] ? (32'd0 - rs) : rs;
                    b_next.div_b = rt[31] ? (32'd0 - rt) : rt;
                end
                else
                begin
                    b_next.item.hi_out = 32'd0;
                    b_next.item.lo_out = 32'd0;
                end
            end
            OP_DIVU:
            begin
                if (rt != 32'd0)
                begin
                    b_next.dctl.div_en = 1'b1;
                end
                else
                begin
                    b_next.item.hi_out = 32'd0;
                    b_next.item.lo_out = 32'd0;
                end
            end
            OP_ADD:
            begin
                b_next.item.result_value = sum;
                if (rs[31] == rt[31] && sum[31] != rs[31])
                    b_next.item.exception_code = EXC_OVERFLOW;
            end
            OP_ADDU: b_next.item.result_value = sum;
            OP_SUB:
            begin
                b_next.item.result_value = dif;
                if (rs[31] != rt[31] && dif[31] != rs[31])
                    b_next.item.exception_code = EXC_OVERFLOW;
            end
            OP_SUBU: b_next.item.result_value = dif;
            OP_AND:  b_next.item.result_value = rs & rt;
            OP_OR:   b_next.item.result_value = rs | rt;
            OP_XOR:  b_next.item.result_value = rs ^ rt;
            OP_NOR:  b_next.item.result_value = ~(rs | rt);
            OP_SLT:  b_next.item.result_value = {31'd0, lt_s};
            OP_SLTU: b_next.item.result_value = {31'd0, lt_u};
            OP_TGE:  if (!lt_s) b_next.item.exception_code = EXC_TRAP;
            OP_TGEU: if (!lt_u) b_next.item.exception_code = EXC_TRAP;
            OP_TLT:  if (lt_s)  b_next.item.exception_code = EXC_TRAP;
            OP_TLTU: if (lt_u)  b_next.item.exception_code = EXC_TRAP;
            OP_TEQ:  if (rs == rt) b_next.item.exception_code = EXC_TRAP;
            OP_TNE:  if (rs != rt) b_next.item.exception_code = EXC_TRAP;
            OP_BLTZ, OP_BLTZL:
            begin
                b_next.item.target_pc = btgt;
                b_next.item.condition = rs[31];
            end
            OP_BLTZAL, OP_BLTZALL:
            begin
                b_next.item.target_pc    = btgt;
                b_next.item.condition    = rs[31];
                b_next.item.result_value = link;
            end
            OP_BGEZ, OP_BGEZL:
            begin
                b_next.item.target_pc = btgt;
                b_next.item.condition = ~rs[31];
            end
            OP_BGEZAL, OP_BGEZALL:
            begin
                b_next.item.target_pc    = btgt;
                b_next.item.condition    = ~rs[31];
                b_next.item.result_value = link;
            end
            OP_TGEI:  if (!lti_s) b_next.item.exception_code = EXC_TRAP;
            OP_TGEIU: if (!lti_u) b_next.item.exception_code = EXC_TRAP;
            OP_TLTI:  if (lti_s)  b_next.item.exception_code = EXC_TRAP;
            OP_TLTIU: if (lti_u)  b_next.item.exception_code = EXC_TRAP;
            OP_TEQI:  if (rs == si) b_next.item.exception_code = EXC_TRAP;
            OP_TNEI:  if (rs != si) b_next.item.exception_code = EXC_TRAP;
            OP_J:
            begin
                b_next.item.target_pc = {pc[31:28], a_cmd_reg.jump_index, 2'b00};
                b_next.item.condition = 1'b1;
            end
            OP_JAL:
            begin
                b_next.item.target_pc    = {pc[31:28], a_cmd_reg.jump_index, 2'b00};
                b_next.item.condition    = 1'b1;
                b_next.item.result_value = link;
            end
            OP_BEQ, OP_BEQL:
            begin
                b_next.item.target_pc = btgt;
                b_next.item.condition = (rs == rt);
            end
            OP_BNE, OP_BNEL:
            begin
                b_next.item.target_pc = btgt;
                b_next.item.condition = (rs != rt);
            end
            OP_BLEZ, OP_BLEZL:
            begin
                b_next.item.target_pc = btgt;
                b_next.item.condition = rs[31] || (rs == 32'd0);
            end
            OP_BGTZ, OP_BGTZL:
            begin
                b_next.item.target_pc = btgt;
                b_next.item.condition = !rs[31] && (rs != 32'd0);
            end
            OP_ADDI:
            begin
                b_next.item.result_value = addr;
                if (rs[31] == si[31] && addr[31] != si[31])
                    b_next.item.exception_code = EXC_OVERFLOW;
            end
            OP_ADDIU: b_next.item.result_value = addr;
            OP_SLTI:  b_next.item.result_value = {31'd0, lti_s};
            OP_SLTIU: b_next.item.result_value = {31'd0, lti_u};
            OP_ANDI:  b_next.item.result_value = rs & {16'd0, a_cmd_reg.immediate};
            OP_ORI:   b_next.item.result_value = rs | {16'd0, a_cmd_reg.immediate};
            OP_XORI:  b_next.item.result_value = rs ^ {16'd0, a_cmd_reg.immediate};
            OP_LUI:   b_next.item.result_value = {a_cmd_reg.immediate, 16'd0};
            OP_MADD:
            begin
                b_next.mul_signed = 1'b1;
                b_next.acc_add    = 1'b1;
            end
            OP_MADDU: b_next.acc_add = 1'b1;
            OP_MUL:   b_next.mul_res = 1'b1;
            OP_MSUB:
            begin
                b_next.mul_signed = 1'b1;
                b_next.acc_sub    = 1'b1;
            end
            OP_MSUBU: b_next.acc_sub = 1'b1;
            OP_CLZ:   b_next.item.result_value = {26'd0, clz32(rs)};
            OP_CLO:   b_next.item.result_value = {26'd0, clz32(~rs)};
            OP_LB, OP_LBU, OP_LWL, OP_LWR, OP_SB, OP_SWL, OP_SWR:
                b_next.item.mem_address = addr;
            OP_LH, OP_LHU, OP_SH:
            begin
                b_next.item.mem_address = addr;
                if (addr[0]) b_next.item.exception_code = EXC_MISALIGN;
            end
            OP_LW, OP_LL, OP_SW, OP_SC:
            begin
                b_next.item.mem_address = addr;
                if (addr[1:0] != 2'b00) b_next.item.exception_code = EXC_MISALIGN;
            end
            default: b_next.item.undefined_op = 1'b1;
        endcase
    end

    // Stage C: turn the unsigned product into the signed one by correcting its upper word.
    always_comb begin
        c_next = b_reg;
        if (b_reg.mul_signed)
        begin
            c_next.prod[63:32] = b_reg.prod[63:32] - b_reg.corr;
        end
    end

    // Stage D: write hi/lo from the product, or accumulate into the incoming hi/lo pair.
    logic [63:0] acc;

    always_comb begin
        d_next = c_reg;
        acc    = {c_reg.item.hi_out, c_reg.item.lo_out};
        if (c_reg.acc_add)
        begin
            acc = acc + c_reg.prod;
        end
        else if (c_reg.acc_sub)
        begin
            acc = acc - c_reg.prod;
        end
        else if (c_reg.mul_hilo)
        begin
            acc = c_reg.prod;
        end
        d_next.item.hi_out = acc[63:32];
        d_next.item.lo_out = acc[31:0];
        if (c_reg.mul_res)
        begin
            d_next.item.result_value = c_reg.prod[31:0];
        end
    end

    // Divider stages; the final register of the divider drives the result port.
    mexu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (d_valid_reg),
        .dividend  (d_reg.div_a),
        .divisor   (d_reg.div_b),
        .ctl       (d_reg.dctl),
        .item_in   (d_reg.item),
        .valid_out (done),
        .item_out  (result)
    );

    assign busy = 1'b0;

endmodule
`default_nettype wire
